// File: hdl/ass_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ass_pkg: shared types and constants of the step sequencer
// Function codes, event kinds, register indexes and the queue entry type.
// ----------------------------------------------------------------------------
package ass_pkg;
    localparam int STEP_COUNT_D      = 16;
    localparam int TICKS_PER_STEP_D  = 24;
    localparam int QUEUE_DEPTH_D     = 4;

    localparam logic [2:0] FN_TICK   = 3'd0;
    localparam logic [2:0] FN_BLOCK  = 3'd1;
    localparam logic [2:0] FN_WRITE  = 3'd2;
    localparam logic [2:0] FN_CLEAR  = 3'd3;
    localparam logic [2:0] FN_READ   = 3'd4;

    localparam logic [1:0] KIND_OFF  = 2'd0;
    localparam logic [1:0] KIND_ON   = 2'd1;
    localparam logic [1:0] KIND_READ = 2'd2;

    localparam logic [2:0] REG_LOOP_LEN  = 3'd0;
    localparam logic [2:0] REG_LOOP_ST   = 3'd1;
    localparam logic [2:0] REG_GATE_LEN  = 3'd2;
    localparam logic [2:0] REG_ACCENT    = 3'd3;
    localparam logic [2:0] REG_NORMAL    = 3'd4;

    // classified command handed from the front to the back
    typedef struct packed {
        logic [2:0]  func;
        logic [31:0] abs_tick;
        logic [6:0]  offset;
        logic        wrapped;
        logic [3:0]  index;
        logic [6:0]  note;
        logic        gate;
        logic        accent;
        logic        slide;
    } t_cmd;

    typedef struct packed {
        logic [1:0] kind;
        logic [6:0] note;
        logic [6:0] velocity;
        logic       tie;
        logic [6:0] offset;
        logic       read_gate;
        logic       read_accent;
        logic [4:0] playing_step;
        logic       last;
    } t_evt;
endpackage

// File: hdl/ass_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ass_in_if / ass_out_if: valid-ready channels of the step sequencer
// Input command channel and output event channel.
// ----------------------------------------------------------------------------
interface ass_in_if;
    logic        valid;
    logic        ready;
    logic [2:0]  func;
    logic [31:0] absolute_tick;
    logic [6:0]  tick_sample_offset;
    logic        loop_wrapped;
    logic [3:0]  step_index;
    logic [7:0]  step_note;
    logic        step_gate;
    logic        step_accent;
    logic        step_slide;
    modport source (output valid, func, absolute_tick, tick_sample_offset, loop_wrapped,
                    step_index, step_note, step_gate, step_accent, step_slide,
                    input ready);
    modport sink (input valid, func, absolute_tick, tick_sample_offset, loop_wrapped,
                  step_index, step_note, step_gate, step_accent, step_slide,
                  output ready);
endinterface

interface ass_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] event_kind;
    logic [6:0] event_note;
    logic [6:0] event_velocity;
    logic       event_tie;
    logic [6:0] event_offset;
    logic       read_gate;
    logic       read_accent;
    logic [4:0] playing_step;
    logic       last;
    modport source (output valid, event_kind, event_note, event_velocity, event_tie,
                    event_offset, read_gate, read_accent, playing_step, last,
                    input ready);
    modport sink (input valid, event_kind, event_note, event_velocity, event_tie,
                  event_offset, read_gate, read_accent, playing_step, last,
                  output ready);
endinterface

// File: hdl/ass_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ass_front: command intake and queue
// Clamp and classify input beats, drop unknown codes, hold them in a FIFO.
// ----------------------------------------------------------------------------
module ass_front #(
    parameter int DEPTH = ass_pkg::QUEUE_DEPTH_D
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    ass_in_if.sink          in_ch,
    output logic            o_cmd_valid,
    output ass_pkg::t_cmd   o_cmd,
    input  logic            i_cmd_pop
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    ass_pkg::t_cmd   r_mem [DEPTH];
    logic [AW-1:0]   r_wp, r_rp;
    logic [AW:0]     r_cnt;
    ass_pkg::t_cmd   w_cmd;
    logic            w_push, w_known;

    assign in_ch.ready = (r_cnt != (AW+1)'(DEPTH));
    assign w_known = (in_ch.func == ass_pkg::FN_TICK) || (in_ch.func == ass_pkg::FN_BLOCK)
                  || (in_ch.func == ass_pkg::FN_WRITE) || (in_ch.func == ass_pkg::FN_CLEAR)
                  || (in_ch.func == ass_pkg::FN_READ);
    assign w_push = in_ch.valid && in_ch.ready && w_known;

    always_comb begin
        w_cmd.func     = in_ch.func;
        w_cmd.abs_tick = in_ch.absolute_tick;
        w_cmd.offset   = in_ch.tick_sample_offset;
        w_cmd.wrapped  = in_ch.loop_wrapped;
        w_cmd.index    = in_ch.step_index;
        w_cmd.note     = in_ch.step_note[7] ? 7'd127 : in_ch.step_note[6:0];
        w_cmd.gate     = in_ch.step_gate;
        w_cmd.accent   = in_ch.step_accent;
        w_cmd.slide    = in_ch.step_slide;
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wp] <= w_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wp <= (r_wp == AW'(DEPTH-1)) ? '0 : r_wp + 1'b1;
            end
            if (i_cmd_pop) begin
                r_rp <= (r_rp == AW'(DEPTH-1)) ? '0 : r_rp + 1'b1;
            end
            r_cnt <= r_cnt + (AW+1)'(w_push) - (AW+1)'(i_cmd_pop);
        end
    end

    assign o_cmd_valid = (r_cnt != '0);
    assign o_cmd       = r_mem[r_rp];

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == (AW+1)'(DEPTH)) |-> !w_push || i_cmd_pop)
        else $error("queue overflow");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd_pop |-> o_cmd_valid)
        else $error("queue underflow");
    a_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_push && !i_cmd_pop) |=> r_cnt == $past(r_cnt) + 1'b1)
        else $error("count slip");
endmodule

// File: hdl/ass_divider.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ass_divider: serial restoring remainder unit
// One quotient bit per cycle; returns dividend modulo a 16-bit divisor.
// ----------------------------------------------------------------------------
module ass_divider (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [31:0] i_dividend,
    input  logic [15:0] i_divisor,
    output logic        o_done,
    output logic [15:0] o_rem
);
    logic [31:0] r_num;
    logic [16:0] r_rem;
    logic [5:0]  r_cnt;
    logic        r_busy;
    logic [16:0] w_sh;
    logic [17:0] w_diff;

    assign w_sh   = {r_rem[15:0], r_num[31]};
    assign w_diff = {1'b0, w_sh} - {2'b0, i_divisor};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
            o_done <= 1'b0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 6'd32;
                r_num  <= i_dividend;
                r_rem  <= '0;
            end else if (r_busy) begin
                r_num <= {r_num[30:0], 1'b0};
                r_rem <= w_diff[17] ? w_sh : w_diff[16:0];
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == 6'd1) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end

    assign o_rem = r_rem[15:0];
endmodule

// File: hdl/ass_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ass_back: pattern store and event sequencer
// Execute queued commands, run the tick fold, emit note events.
// ----------------------------------------------------------------------------
module ass_back #(
    parameter int STEPS = ass_pkg::STEP_COUNT_D,
    parameter int TPS   = ass_pkg::TICKS_PER_STEP_D
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cmd_valid,
    input  ass_pkg::t_cmd   i_cmd,
    output logic            o_cmd_pop,
    input  logic [15:0]     i_loop_len,
    input  logic [31:0]     i_loop_start,
    input  logic [4:0]      i_gate_len,
    input  logic [6:0]      i_accent,
    input  logic [6:0]      i_normal,
    ass_out_if.source       out_ch
);
    localparam int SW = $clog2(STEPS);
    localparam logic [4:0] NO_STEP = 5'd16;
    // reciprocal constants for the step split and the step wrap
    localparam int KT = 23;
    localparam int KS = 22;
    localparam logic [23:0] RT = 24'(((1 << KT) + TPS - 1) / TPS);
    localparam logic [22:0] RS = 23'(((1 << KS) + STEPS - 1) / STEPS);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_DIV  = 4'd1;
    localparam logic [3:0] S_FIX  = 4'd2;
    localparam logic [3:0] S_STEP = 4'd3;
    localparam logic [3:0] S_SQ   = 4'd4;
    localparam logic [3:0] S_RD   = 4'd5;
    localparam logic [3:0] S_PLAY = 4'd6;
    localparam logic [3:0] S_EMIT = 4'd7;
    localparam logic [3:0] S_CLR  = 4'd8;
    localparam logic [3:0] S_MOD  = 4'd9;
    localparam logic [3:0] S_REL  = 4'd10;

    logic [3:0]  r_state;
    logic [6:0]  r_pn [STEPS];
    logic [2:0]  r_pf [STEPS];
    logic [STEPS-1:0] r_pv;
    logic [4:0]  r_cur;
    logic [6:0]  r_snd, r_owed;
    logic        r_held, r_slides, r_owed_v;
    logic [15:0] r_rel;
    ass_pkg::t_cmd r_cmd;
    logic        r_neg;
    logic [15:0] r_fold;
    logic [15:0] r_q, r_r;
    logic [6:0]  r_sn;
    logic [2:0]  r_sf;
    ass_pkg::t_evt r_ev [2];
    logic [1:0]  r_n, r_k;
    logic        r_ovalid;
    ass_pkg::t_evt r_out;
    logic [4:0]  r_ps;

    logic        w_dstart, w_ddone;
    logic [31:0] w_dvd;
    logic [15:0] w_rem;
    logic [16:0] w_sum;
    logic [39:0] w_qp;
    logic [22:0] w_qt;
    logic [38:0] w_sp;
    logic [22:0] w_sm;
    logic [15:0] w_s;
    logic        w_load;
    ass_pkg::t_evt w_rd, w_next;

    ass_divider u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_dstart),
        .i_dividend(w_dvd), .i_divisor(i_loop_len),
        .o_done(w_ddone), .o_rem(w_rem)
    );

    logic r_dgo;

    assign w_dvd = (r_cmd.abs_tick >= i_loop_start) ? r_cmd.abs_tick - i_loop_start
                                                    : i_loop_start - r_cmd.abs_tick;
    assign w_dstart = r_dgo;
    assign o_cmd_pop = (r_state == S_IDLE) && i_cmd_valid && !r_ovalid;

    function automatic ass_pkg::t_evt mk(input logic [1:0] k, input logic [6:0] nt,
                                         input logic [6:0] v, input logic t,
                                         input logic [6:0] o);
        ass_pkg::t_evt e;
        e = '0;
        e.kind = k; e.note = nt; e.velocity = v; e.tie = t; e.offset = o;
        return e;
    endfunction

    logic [15:0] w_gsum;
    assign w_sum  = {1'b0, r_fold} + {12'b0, (i_gate_len == 5'd0) ? 5'd1 : i_gate_len};
    assign w_gsum = w_sum[15:0];

    // split the folded tick into step number and remainder by reciprocal multiply
    assign w_qp = {24'b0, r_fold} * {16'b0, RT};
    assign w_qt = {7'b0, r_q} * 23'(TPS);
    assign w_sp = {23'b0, r_q} * {16'b0, RS};
    assign w_sm = {7'b0, r_r} * 23'(STEPS);
    assign w_s  = r_q - w_sm[15:0];

    assign w_load = (r_state == S_EMIT) && (r_k != r_n) && (!r_ovalid || out_ch.ready);

    always_comb begin
        w_rd = '0;
        w_rd.kind = ass_pkg::KIND_READ;
        if (32'(r_cmd.index) < 32'(STEPS) && r_pv[r_cmd.index[SW-1:0]]) begin
            w_rd.note        = r_pn[r_cmd.index[SW-1:0]];
            w_rd.tie         = r_pf[r_cmd.index[SW-1:0]][0];
            w_rd.read_gate   = r_pf[r_cmd.index[SW-1:0]][2];
            w_rd.read_accent = r_pf[r_cmd.index[SW-1:0]][1];
        end
    end

    always_comb begin
        w_next = r_ev[r_k[0]];
        w_next.last = (r_k + 2'd1 == r_n);
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && o_cmd_pop && i_cmd.func == ass_pkg::FN_WRITE
            && 32'(i_cmd.index) < 32'(STEPS)) begin
            r_pn[i_cmd.index[SW-1:0]] <= i_cmd.note;
            r_pf[i_cmd.index[SW-1:0]] <= {i_cmd.gate, i_cmd.accent, i_cmd.slide};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE; r_pv <= '0; r_cur <= NO_STEP;
            r_snd <= '0; r_owed <= '0; r_held <= 1'b0; r_slides <= 1'b0;
            r_owed_v <= 1'b0; r_rel <= '0; r_n <= '0; r_k <= '0;
            r_ovalid <= 1'b0; r_dgo <= 1'b0;
        end else begin
            r_dgo <= o_cmd_pop && (i_cmd.func == ass_pkg::FN_TICK) && (i_loop_len != 16'd0);
            if (w_load) begin
                r_ovalid <= 1'b1;
            end else if (r_ovalid && out_ch.ready) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (o_cmd_pop) begin
                        r_cmd <= i_cmd;
                        r_n   <= '0;
                        r_k   <= '0;
                        case (i_cmd.func)
                            ass_pkg::FN_WRITE: begin
                                if (32'(i_cmd.index) < 32'(STEPS)) begin
                                    r_pv[i_cmd.index[SW-1:0]] <= 1'b1;
                                end
                            end
                            ass_pkg::FN_CLEAR: begin
                                r_pv <= '0; r_cur <= NO_STEP;
                                if (r_held) begin
                                    r_owed <= r_snd; r_owed_v <= 1'b1;
                                end
                                r_held <= 1'b0; r_slides <= 1'b0;
                            end
                            ass_pkg::FN_READ:  r_state <= S_RD;
                            ass_pkg::FN_BLOCK: r_state <= S_PLAY;
                            ass_pkg::FN_TICK: begin
                                if (i_loop_len != 16'd0) begin
                                    r_state <= S_DIV;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                S_DIV: begin
                    r_neg <= (r_cmd.abs_tick < i_loop_start);
                    if (w_ddone) r_state <= S_FIX;
                end
                S_FIX: begin
                    if (r_neg && w_rem != 16'd0) r_fold <= i_loop_len - w_rem;
                    else r_fold <= w_rem;
                    r_state <= S_STEP;
                end
                S_STEP: begin
                    // release at gate tick, then take the step quotient
                    if (r_held && !r_slides && r_fold == r_rel) begin
                        r_ev[0] <= mk(ass_pkg::KIND_OFF, r_snd, 7'd0, 1'b0, r_cmd.offset);
                        r_n <= 2'd1; r_held <= 1'b0;
                    end
                    r_q <= w_qp[38:23];
                    r_state <= S_SQ;
                end
                S_SQ: begin
                    // off a step boundary nothing more happens
                    if ({7'b0, r_fold} != w_qt) begin
                        r_state <= S_EMIT;
                    end else begin
                        r_r <= w_sp[37:22];
                        r_state <= S_MOD;
                    end
                end
                S_MOD: begin
                    r_cur <= 5'(w_s[SW-1:0]);
                    r_sn <= r_pv[w_s[SW-1:0]] ? r_pn[w_s[SW-1:0]] : 7'd0;
                    r_sf <= r_pv[w_s[SW-1:0]] ? r_pf[w_s[SW-1:0]] : 3'd0;
                    r_state <= S_PLAY;
                end
                S_RD: begin
                    r_ev[0] <= w_rd;
                    r_n <= 2'd1;
                    r_state <= S_EMIT;
                end
                S_PLAY: begin
                    if (r_cmd.func == ass_pkg::FN_BLOCK) begin
                        r_state <= S_EMIT;
                        if (r_owed_v) begin
                            r_ev[0] <= mk(ass_pkg::KIND_OFF, r_owed, 7'd0, 1'b0, 7'd0);
                            r_owed_v <= 1'b0;
                            if (r_cmd.wrapped && r_held)
                                r_ev[1] <= mk(ass_pkg::KIND_OFF, r_snd, 7'd0, 1'b0, 7'd0);
                        end else begin
                            r_ev[0] <= mk(ass_pkg::KIND_OFF, r_snd, 7'd0, 1'b0, 7'd0);
                        end
                        r_n <= 2'(r_owed_v) + 2'(r_cmd.wrapped && r_held);
                        if (r_cmd.wrapped && r_held) begin
                            r_held <= 1'b0; r_slides <= 1'b0;
                        end
                    end else if (!r_sf[2]) begin
                        r_state <= S_EMIT;
                        if (r_held && !r_slides) begin
                            r_ev[r_n[0]] <= mk(ass_pkg::KIND_OFF, r_snd, 7'd0, 1'b0,
                                               r_cmd.offset);
                            r_n <= r_n + 1'b1; r_held <= 1'b0;
                        end
                    end else begin
                        r_state <= S_REL;
                        // at most two beats: held release was taken or is taken now
                        if (r_held && r_slides) begin
                            r_ev[r_n[0]] <= mk(ass_pkg::KIND_ON, r_sn,
                                               r_sf[1] ? i_accent : i_normal, 1'b1,
                                               r_cmd.offset);
                            r_ev[~r_n[0]] <= mk(ass_pkg::KIND_OFF, r_snd, 7'd0, 1'b0,
                                                r_cmd.offset);
                            r_n <= r_n + 2'd2;
                        end else if (r_held) begin
                            r_ev[0] <= mk(ass_pkg::KIND_OFF, r_snd, 7'd0, 1'b0,
                                          r_cmd.offset);
                            r_ev[1] <= mk(ass_pkg::KIND_ON, r_sn,
                                          r_sf[1] ? i_accent : i_normal, 1'b0,
                                          r_cmd.offset);
                            r_n <= 2'd2;
                        end else begin
                            r_ev[r_n[0]] <= mk(ass_pkg::KIND_ON, r_sn,
                                               r_sf[1] ? i_accent : i_normal, 1'b0,
                                               r_cmd.offset);
                            r_n <= r_n + 1'b1;
                        end
                        r_snd <= r_sn; r_slides <= r_sf[0]; r_held <= 1'b1;
                        r_rel <= (w_sum >= {1'b0, i_loop_len}) ? w_gsum - i_loop_len
                                                               : w_gsum;
                    end
                end
                S_REL: begin
                    // loops shorter than the gate need more than one wrap
                    if (r_rel >= i_loop_len) r_rel <= r_rel - i_loop_len;
                    else r_state <= S_EMIT;
                end
                S_EMIT: begin
                    if (r_k == r_n) begin
                        r_state <= S_IDLE;
                    end else if (w_load) begin
                        r_out <= w_next;
                        r_ps <= r_cur;
                        r_k <= r_k + 1'b1;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign out_ch.valid          = r_ovalid;
    assign out_ch.event_kind     = r_out.kind;
    assign out_ch.event_note     = r_out.note;
    assign out_ch.event_velocity = r_out.velocity;
    assign out_ch.event_tie      = r_out.tie;
    assign out_ch.event_offset   = r_out.offset;
    assign out_ch.read_gate      = r_out.read_gate;
    assign out_ch.read_accent    = r_out.read_accent;
    assign out_ch.playing_step   = r_ps;
    assign out_ch.last           = r_out.last;

    a_emit_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT) |-> r_n <= 2'd2)
        else $error("too many events");
    a_cur_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cur <= NO_STEP)
        else $error("step out of range");
    a_pop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd_pop |-> r_state == S_IDLE)
        else $error("pop while busy");
endmodule

// File: hdl/acid_step_sequencer_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acid_step_sequencer_unit: 16-step gate/accent/slide pattern sequencer
// Front queue feeds a back end that folds ticks and streams note events.
// ----------------------------------------------------------------------------
// Flow: write/clear pass the front queue and act when the idle back end pops them;
// read and block start load their events, which leave through the output register.
// Tick: the serial remainder unit folds the tick, then the fix, step and boundary
// states, plus lookup and play on a boundary; loops under the gate add S_REL wraps.
// Throughput: one item in the back end at a time; the front queue takes
// up to four beats meanwhile. Reset: synchronous, active low; pattern reads as rests.
module acid_step_sequencer_unit #(
    parameter int STEP_COUNT       = ass_pkg::STEP_COUNT_D,
    parameter int TICKS_PER_STEP_N = ass_pkg::TICKS_PER_STEP_D
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ass_in_if.sink      in_ch,
    ass_out_if.source   out_ch,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);
    logic [15:0] r_loop_len;
    logic [31:0] r_loop_start;
    logic [4:0]  r_gate_len;
    logic [6:0]  r_accent, r_normal;
    logic          w_cvalid, w_pop;
    ass_pkg::t_cmd w_cmd;

    // hold configuration; the user must write only while idle, the block does not enforce it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_loop_len <= 16'd384; r_loop_start <= '0; r_gate_len <= 5'd12;
            r_accent <= 7'd127; r_normal <= 7'd100;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                ass_pkg::REG_LOOP_LEN: r_loop_len   <= i_cfg_data[15:0];
                ass_pkg::REG_LOOP_ST:  r_loop_start <= i_cfg_data;
                ass_pkg::REG_GATE_LEN: r_gate_len   <= i_cfg_data[4:0];
                ass_pkg::REG_ACCENT:   r_accent     <= i_cfg_data[6:0];
                ass_pkg::REG_NORMAL:   r_normal     <= i_cfg_data[6:0];
                default: ;
            endcase
        end
    end

    ass_front #(.DEPTH(ass_pkg::QUEUE_DEPTH_D)) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .in_ch(in_ch),
        .o_cmd_valid(w_cvalid), .o_cmd(w_cmd), .i_cmd_pop(w_pop)
    );

    ass_back #(.STEPS(STEP_COUNT), .TPS(TICKS_PER_STEP_N)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd_valid(w_cvalid), .i_cmd(w_cmd),
        .o_cmd_pop(w_pop), .i_loop_len(r_loop_len), .i_loop_start(r_loop_start),
        .i_gate_len(r_gate_len), .i_accent(r_accent), .i_normal(r_normal),
        .out_ch(out_ch)
    );
endmodule

// File: sim/tb_acid_step_sequencer_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_acid_step_sequencer_unit: self-checking bench of the step sequencer
// Drives commands through the input channel and predicts every event in a
// behavioral copy of the pattern store and voice state. Each output beat is
// checked field by field against the oldest predicted event. Both channel
// sides stall in random bursts. The register set is swept between phases.
// ----------------------------------------------------------------------------
module tb_acid_step_sequencer_unit;
    localparam int WATCHDOG_LIMIT = 20000;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [2:0] i_cfg_index;
    logic [31:0] i_cfg_data;

    ass_in_if in_ch ();
    ass_out_if out_ch ();

    acid_step_sequencer_unit dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .in_ch(in_ch), .out_ch(out_ch),
        .i_cfg_we(i_cfg_we), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    // Shadow copy of the registers and the voice state.
    logic [15:0] loop_len;
    logic [31:0] loop_base;
    logic [4:0] gate_len;
    logic [6:0] accent_vel;
    logic [6:0] normal_vel;
    logic [6:0] pat_note [16];
    logic pat_gate [16];
    logic pat_accent [16];
    logic pat_slide [16];
    logic [4:0] cur_step;
    logic [6:0] sound_note;
    logic held;
    logic slides;
    logic [15:0] rel_tick;
    logic owed;
    logic [6:0] owed_note_q;

    ass_pkg::t_evt pending_events [$];
    ass_pkg::t_evt step_events [$];
    int errors;
    int idle_cycles;
    bit stall_enable;
    bit hold_off;
    int hold_cycles;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        errors++;
    endtask

    function automatic ass_pkg::t_evt make_event(input logic [1:0] kind,
                                                 input logic [6:0] note,
                                                 input logic [6:0] vel, input logic tie,
                                                 input logic [6:0] offs, input logic g,
                                                 input logic a);
        ass_pkg::t_evt e;
        e = '0;
        e.kind = kind;
        e.note = note;
        e.velocity = vel;
        e.tie = tie;
        e.offset = offs;
        e.read_gate = g;
        e.read_accent = a;
        return e;
    endfunction

    // Predict the events of one accepted command; stamp step and last flag.
    task automatic predict_events(input ass_pkg::t_cmd c);
        logic [31:0] folded;
        logic [31:0] gate_eff;
        int s;
        logic tie;
        step_events.delete();
        case (c.func)
            ass_pkg::FN_WRITE: begin
                pat_note[c.index] = c.note;
                pat_gate[c.index] = c.gate;
                pat_accent[c.index] = c.accent;
                pat_slide[c.index] = c.slide;
            end
            ass_pkg::FN_READ: begin
                step_events.push_back(make_event(ass_pkg::KIND_READ, pat_note[c.index],
                    7'd0, pat_slide[c.index], 7'd0, pat_gate[c.index],
                    pat_accent[c.index]));
            end
            ass_pkg::FN_CLEAR: begin
                for (int i = 0; i < 16; i++) begin
                    pat_note[i] = '0;
                    pat_gate[i] = 1'b0;
                    pat_accent[i] = 1'b0;
                    pat_slide[i] = 1'b0;
                end
                cur_step = 5'd16;
                if (held) begin
                    owed_note_q = sound_note;
                    owed = 1'b1;
                end
                held = 1'b0;
                slides = 1'b0;
            end
            ass_pkg::FN_BLOCK: begin
                if (owed) begin
                    step_events.push_back(make_event(ass_pkg::KIND_OFF, owed_note_q, 7'd0,
                                                     1'b0, 7'd0, 1'b0, 1'b0));
                    owed = 1'b0;
                end
                if (c.wrapped && held) begin
                    step_events.push_back(make_event(ass_pkg::KIND_OFF, sound_note, 7'd0,
                                                     1'b0, 7'd0, 1'b0, 1'b0));
                    held = 1'b0;
                    slides = 1'b0;
                end
            end
            ass_pkg::FN_TICK: begin
                if (loop_len != 0) begin
                    gate_eff = (gate_len == 0) ? 32'd1 : 32'(gate_len);
                    if (c.abs_tick >= loop_base)
                        folded = (c.abs_tick - loop_base) % loop_len;
                    else
                        folded = (loop_len - ((loop_base - c.abs_tick) % loop_len)) % loop_len;
                    if (held && !slides && folded == 32'(rel_tick)) begin
                        step_events.push_back(make_event(ass_pkg::KIND_OFF, sound_note,
                                                         7'd0, 1'b0, c.offset, 1'b0, 1'b0));
                        held = 1'b0;
                    end
                    if (folded % 24 == 0) begin
                        s = (folded / 24) % 16;
                        cur_step = 5'(s);
                        if (!pat_gate[s]) begin
                            if (held && !slides) begin
                                step_events.push_back(make_event(ass_pkg::KIND_OFF,
                                    sound_note, 7'd0, 1'b0, c.offset, 1'b0, 1'b0));
                                held = 1'b0;
                            end
                        end else begin
                            tie = held && slides;
                            if (held && !tie) begin
                                step_events.push_back(make_event(ass_pkg::KIND_OFF,
                                    sound_note, 7'd0, 1'b0, c.offset, 1'b0, 1'b0));
                                held = 1'b0;
                            end
                            step_events.push_back(make_event(ass_pkg::KIND_ON, pat_note[s],
                                pat_accent[s] ? accent_vel : normal_vel, tie, c.offset,
                                1'b0, 1'b0));
                            if (tie)
                                step_events.push_back(make_event(ass_pkg::KIND_OFF,
                                    sound_note, 7'd0, 1'b0, c.offset, 1'b0, 1'b0));
                            sound_note = pat_note[s];
                            slides = pat_slide[s];
                            held = 1'b1;
                            rel_tick = 16'((folded + gate_eff) % loop_len);
                        end
                    end
                end
            end
            default: ;
        endcase
        foreach (step_events[k]) begin
            step_events[k].playing_step = cur_step;
            step_events[k].last = (k == step_events.size() - 1);
            pending_events.push_back(step_events[k]);
        end
    endtask

    // Present one command and hold it until the beat is taken.
    task automatic send_cmd(input ass_pkg::t_cmd c);
        int gap;
        if (stall_enable && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 19);
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.func <= c.func;
        in_ch.absolute_tick <= c.abs_tick;
        in_ch.tick_sample_offset <= c.offset;
        in_ch.loop_wrapped <= c.wrapped;
        in_ch.step_index <= c.index;
        in_ch.step_note <= {($urandom_range(0, 1) == 1) && c.note == 7'd127, c.note};
        in_ch.step_gate <= c.gate;
        in_ch.step_accent <= c.accent;
        in_ch.step_slide <= c.slide;
        do @(posedge i_clk); while (!in_ch.ready);
        predict_events(c);
    endtask

    function automatic ass_pkg::t_cmd rand_cmd(input logic [2:0] f);
        ass_pkg::t_cmd c;
        c.func = f;
        c.abs_tick = $urandom;
        c.offset = 7'($urandom);
        c.wrapped = 1'($urandom);
        c.index = 4'($urandom);
        c.note = 7'($urandom);
        c.gate = 1'($urandom);
        c.accent = 1'($urandom);
        c.slide = 1'($urandom);
        return c;
    endfunction

    task automatic send_tick(input logic [31:0] t);
        ass_pkg::t_cmd c;
        c = rand_cmd(ass_pkg::FN_TICK);
        c.abs_tick = t;
        send_cmd(c);
    endtask

    task automatic send_write(input logic [3:0] idx, input logic [6:0] note,
                              input logic g, input logic a, input logic sl);
        ass_pkg::t_cmd c;
        c = rand_cmd(ass_pkg::FN_WRITE);
        c.index = idx;
        c.note = note;
        c.gate = g;
        c.accent = a;
        c.slide = sl;
        send_cmd(c);
    endtask

    // Wait for the event queue to drain and the back end to settle.
    task automatic drain_events();
        in_ch.valid <= 1'b0;
        while (pending_events.size() != 0) @(posedge i_clk);
        repeat (500) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            ass_pkg::REG_LOOP_LEN: loop_len = val[15:0];
            ass_pkg::REG_LOOP_ST: loop_base = val;
            ass_pkg::REG_GATE_LEN: gate_len = val[4:0];
            ass_pkg::REG_ACCENT: accent_vel = val[6:0];
            ass_pkg::REG_NORMAL: normal_vel = val[6:0];
            default: ;
        endcase
    endtask

    task automatic set_regs(input logic [15:0] len, input logic [31:0] base,
                            input logic [4:0] gl, input logic [6:0] acc,
                            input logic [6:0] nrm);
        drain_events();
        write_reg(ass_pkg::REG_LOOP_LEN, 32'(len));
        write_reg(ass_pkg::REG_LOOP_ST, base);
        write_reg(ass_pkg::REG_GATE_LEN, 32'(gl));
        write_reg(ass_pkg::REG_ACCENT, 32'(acc));
        write_reg(ass_pkg::REG_NORMAL, 32'(nrm));
    endtask

    // Directed: field extremes, every function, rests, slides, owed release.
    task automatic test_directed();
        ass_pkg::t_cmd c;
        send_write(4'd0, 7'd127, 1'b1, 1'b1, 1'b0);
        send_write(4'd1, 7'd0, 1'b1, 1'b0, 1'b1);
        send_write(4'd2, 7'd64, 1'b1, 1'b0, 1'b0);
        send_write(4'd3, 7'd10, 1'b0, 1'b0, 1'b0);
        send_write(4'd15, 7'd1, 1'b1, 1'b1, 1'b1);
        for (int i = 0; i < 5; i++) begin
            c = rand_cmd(ass_pkg::FN_READ);
            c.index = (i == 4) ? 4'd15 : 4'(i);
            send_cmd(c);
        end
        send_tick(32'd0);
        send_tick(32'd12);
        send_tick(32'd24);
        send_tick(32'd48);
        send_tick(32'd72);
        send_tick(32'd360);
        send_tick(32'hFFFF_FFFF);
        c = rand_cmd(ass_pkg::FN_CLEAR);
        send_cmd(c);
        c = rand_cmd(ass_pkg::FN_BLOCK);
        c.wrapped = 1'b0;
        send_cmd(c);
        send_write(4'd0, 7'd5, 1'b1, 1'b0, 1'b1);
        send_tick(32'd0);
        c.wrapped = 1'b1;
        send_cmd(c);
        c = rand_cmd(3'd5);
        send_cmd(c);
        c = rand_cmd(3'd7);
        send_cmd(c);
    endtask

    // Random: mostly a running transport with sparse noise and edits.
    task automatic test_random(input int count, input bit idle);
        logic [31:0] t;
        int r;
        ass_pkg::t_cmd c;
        stall_enable = idle;
        t = $urandom;
        for (int i = 0; i < count; i++) begin
            r = $urandom_range(0, 99);
            if (r < 60) begin
                t = t + (($urandom_range(0, 3) == 0) ? 32'($urandom_range(1, 30)) : 32'd1);
                send_tick(t);
            end else if (r < 64) begin
                send_tick($urandom);
            end else if (r < 78) begin
                c = rand_cmd(ass_pkg::FN_WRITE);
                send_cmd(c);
            end else if (r < 86) begin
                send_cmd(rand_cmd(ass_pkg::FN_READ));
            end else if (r < 95) begin
                send_cmd(rand_cmd(ass_pkg::FN_BLOCK));
            end else if (r < 98) begin
                send_cmd(rand_cmd(ass_pkg::FN_CLEAR));
            end else begin
                send_cmd(rand_cmd(3'($urandom_range(5, 7))));
            end
        end
    endtask

    // Fill the pattern so that most step boundaries produce events.
    task automatic fill_pattern();
        for (int i = 0; i < 16; i++)
            send_write(4'(i), 7'($urandom), $urandom_range(0, 3) != 0, 1'($urandom),
                       1'($urandom));
    endtask

    // Hold the receiver off for a long stretch while ticks keep coming.
    task automatic test_backpressure();
        hold_cycles = 600;
        hold_off = 1'b1;
        for (int i = 0; i < 30; i++) send_tick(32'(i * 24));
    endtask

    // Receiver: random ready bursts, plus the long hold-off.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
            idle_cycles <= 0;
        end else if (hold_off) begin
            out_ch.ready <= 1'b0;
            hold_cycles <= hold_cycles - 1;
            if (hold_cycles <= 1) hold_off <= 1'b0;
        end else if (idle_cycles > 0) begin
            out_ch.ready <= 1'b0;
            idle_cycles <= idle_cycles - 1;
        end else if (stall_enable && $urandom_range(0, 7) == 0) begin
            out_ch.ready <= 1'b0;
            idle_cycles <= $urandom_range(0, 18);
        end else begin
            out_ch.ready <= 1'b1;
        end
    end

    // Compare each output beat with the oldest predicted event.
    always @(posedge i_clk) begin
        ass_pkg::t_evt want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (pending_events.size() == 0) begin
                report_mismatch("unexpected beat kind", out_ch.event_kind, -1);
            end else begin
                want = pending_events.pop_front();
                if (out_ch.event_kind !== want.kind)
                    report_mismatch("event_kind", out_ch.event_kind, want.kind);
                if (out_ch.event_note !== want.note)
                    report_mismatch("event_note", out_ch.event_note, want.note);
                if (out_ch.event_velocity !== want.velocity)
                    report_mismatch("event_velocity", out_ch.event_velocity, want.velocity);
                if (out_ch.event_tie !== want.tie)
                    report_mismatch("event_tie", out_ch.event_tie, want.tie);
                if (out_ch.event_offset !== want.offset)
                    report_mismatch("event_offset", out_ch.event_offset, want.offset);
                if (out_ch.read_gate !== want.read_gate)
                    report_mismatch("read_gate", out_ch.read_gate, want.read_gate);
                if (out_ch.read_accent !== want.read_accent)
                    report_mismatch("read_accent", out_ch.read_accent, want.read_accent);
                if (out_ch.playing_step !== want.playing_step)
                    report_mismatch("playing_step", out_ch.playing_step, want.playing_step);
                if (out_ch.last !== want.last)
                    report_mismatch("last", out_ch.last, want.last);
            end
        end
    end

    // Watchdog: count cycles with no beat on either channel.
    int quiet_cycles;
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial begin
        errors = 0;
        quiet_cycles = 0;
        stall_enable = 1'b0;
        hold_off = 1'b0;
        hold_cycles = 0;
        idle_cycles = 0;
        i_rst_n <= 1'b0;
        i_cfg_we <= 1'b0;
        i_cfg_index <= '0;
        i_cfg_data <= '0;
        in_ch.valid <= 1'b0;
        in_ch.func <= ass_pkg::FN_TICK;
        in_ch.absolute_tick <= '0;
        in_ch.tick_sample_offset <= '0;
        in_ch.loop_wrapped <= 1'b0;
        in_ch.step_index <= '0;
        in_ch.step_note <= '0;
        in_ch.step_gate <= 1'b0;
        in_ch.step_accent <= 1'b0;
        in_ch.step_slide <= 1'b0;
        loop_len = 16'd384;
        loop_base = '0;
        gate_len = 5'd12;
        accent_vel = 7'd127;
        normal_vel = 7'd100;
        for (int i = 0; i < 16; i++) begin
            pat_note[i] = '0;
            pat_gate[i] = 1'b0;
            pat_accent[i] = 1'b0;
            pat_slide[i] = 1'b0;
        end
        cur_step = 5'd16;
        sound_note = '0;
        held = 1'b0;
        slides = 1'b0;
        rel_tick = '0;
        owed = 1'b0;
        owed_note_q = '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        set_regs(16'd384, 32'd100, 5'd23, 7'd0, 7'd127);
        fill_pattern();
        test_backpressure();
        test_random(400, 1'b1);
        set_regs(16'd0, 32'hFFFF_FFF0, 5'd0, 7'd127, 7'd0);
        test_random(60, 1'b1);
        set_regs(16'd24, 32'd5, 5'd1, 7'd90, 7'd30);
        fill_pattern();
        test_random(350, 1'b1);
        set_regs(16'hFFFF, 32'hFFFF_FFFF, 5'd0, 7'd64, 7'd1);
        fill_pattern();
        test_random(300, 1'b1);
        set_regs(16'd96, 32'($urandom), 5'($urandom_range(1, 23)), 7'($urandom),
                 7'($urandom));
        fill_pattern();
        test_random(350, 1'b1);
        // final stretch without idling on either side
        test_random(200, 1'b0);

        drain_events();
        if (errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end
endmodule

// File: acid_step_sequencer_unit.f
hdl/ass_pkg.sv
hdl/ass_if.sv
hdl/ass_front.sv
hdl/ass_divider.sv
hdl/ass_back.sv
hdl/acid_step_sequencer_unit.sv
sim/tb_acid_step_sequencer_unit.sv
